FILE: design/ecvm_pkg.sv
// ----------------------------------------------------------------------------
// ecvm_pkg: shared types and constants of the camera view matrix block
// Sine polynomial coefficients, pipeline item types and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none
package ecvm_pkg;

  localparam int ANGLE_BITS_DEF     = 16;
  localparam int UNIT_FRAC_BITS_DEF = 14;
  localparam int POS_W   = 32;
  localparam int UNIT_W  = 16;
  localparam int TRANS_W = 33;
  localparam int ACC_W   = 40;
  localparam int NCOEF   = 6;

  localparam logic signed [ACC_W-1:0] ONE_Q30 = 40'sd1073741824;

  // horner coefficients in q30, highest order first
  function automatic logic signed [ACC_W-1:0] coef(input int i);
    logic signed [ACC_W-1:0] c;
    begin
      case (i)
        0: c = -40'sd3864;
        1: c = 40'sd172273;
        2: c = -40'sd5026995;
        3: c = 40'sd85569306;
        4: c = -40'sd693598668;
        default: c = 40'sd1686629713;
      endcase
      return c;
    end
  endfunction

  // q30 product rounded half away from zero
  function automatic logic signed [ACC_W-1:0] mul_q30(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] na, nb;
    logic [31:0] ma, mb;
    logic [63:0] m;
    logic neg;
    begin
      neg = a[ACC_W-1] ^ b[ACC_W-1];
      na = a[ACC_W-1] ? -a : a;
      nb = b[ACC_W-1] ? -b : b;
      // operand magnitudes stay below 2^31 (sines, u, u squared, horner sums)
      ma = na[31:0];
      mb = nb[31:0];
      m = (ma * mb + (64'd1 << 29)) >> 30;
      return neg ? -$signed(m[ACC_W-1:0]) : $signed(m[ACC_W-1:0]);
    end
  endfunction

  // one sine evaluation travelling down the cell chain
  typedef struct packed {
    logic signed [ACC_W-1:0] u;
    logic signed [ACC_W-1:0] u2;
    logic signed [ACC_W-1:0] acc;
    logic                    full;
    logic                    neg;
  } sin_lane_t;

  // pose item travelling down the chain
  typedef struct packed {
    sin_lane_t [3:0]          lane;
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic signed [POS_W-1:0]  pz;
  } pose_t;

endpackage
`default_nettype wire

FILE: design/ecvm_horner_cell.sv
// ----------------------------------------------------------------------------
// ecvm_horner_cell: one horner step for four sine lanes
// Registers acc = coef + acc*u2 per lane and passes the pose on.
// ----------------------------------------------------------------------------
`default_nettype none
module ecvm_horner_cell #(
  parameter int STEP = 1
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            en,
  input  wire            vin,
  input  ecvm_pkg::pose_t din,
  output logic           vout,
  output ecvm_pkg::pose_t dout
);
  ecvm_pkg::pose_t nxt;

  // horner step on every lane
  always_comb begin
    nxt = din;
    for (int i = 0; i < 4; i++) begin
      nxt.lane[i].acc = ecvm_pkg::coef(STEP) + ecvm_pkg::mul_q30(din.lane[i].acc, din.lane[i].u2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end
endmodule
`default_nettype wire

FILE: design/ecvm_out_cell.sv
// ----------------------------------------------------------------------------
// ecvm_out_cell: basis and translation stages
// Finishes the sines, forms the basis, then the dot products, registered.
// ----------------------------------------------------------------------------
`default_nettype none
module ecvm_out_cell #(
  parameter int UNIT_FRAC_BITS = ecvm_pkg::UNIT_FRAC_BITS_DEF
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             en,
  input  wire             vin,
  input  ecvm_pkg::pose_t din,
  output logic            vout,
  output logic [8:0][ecvm_pkg::UNIT_W-1:0]  unit,
  output logic [2:0][ecvm_pkg::TRANS_W-1:0] trans
);
  localparam int SH = 30 - UNIT_FRAC_BITS;
  localparam int PW = ecvm_pkg::POS_W + ecvm_pkg::ACC_W;
  localparam int MW = 2 * ecvm_pkg::POS_W;

  typedef logic signed [ecvm_pkg::ACC_W-1:0] a_t;

  function automatic a_t rshift(input a_t v, input int s);
    a_t m;
    begin
      if (s == 0) return v;
      m = v[ecvm_pkg::ACC_W-1] ? -v : v;
      m = (m + (a_t'(1) <<< (s - 1))) >>> s;
      return v[ecvm_pkg::ACC_W-1] ? -m : m;
    end
  endfunction

  // stage a: final sines
  a_t [3:0] s_q;
  logic va;
  logic signed [ecvm_pkg::POS_W-1:0] pxa, pya, pza;
  a_t [3:0] s_n;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a_t t;
      t = ecvm_pkg::mul_q30(din.lane[i].acc, din.lane[i].u);
      if (din.lane[i].full) t = ecvm_pkg::ONE_Q30;
      if (t < 0) t = '0;
      if (t > ecvm_pkg::ONE_Q30) t = ecvm_pkg::ONE_Q30;
      s_n[i] = din.lane[i].neg ? -t : t;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= vin;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s_q <= s_n;
      pxa <= din.px;
      pya <= din.py;
      pza <= din.pz;
    end
  end

  // stage b: basis vectors (lanes: sh, ch, se, ce)
  a_t [8:0] v_q, v_n;
  logic vb;
  logic signed [ecvm_pkg::POS_W-1:0] pxb, pyb, pzb;
  always_comb begin
    v_n[0] = rshift(-s_q[0], SH);
    v_n[1] = '0;
    v_n[2] = rshift(-s_q[1], SH);
    v_n[3] = rshift(-ecvm_pkg::mul_q30(s_q[2], s_q[1]), SH);
    v_n[4] = rshift(s_q[3], SH);
    v_n[5] = rshift(ecvm_pkg::mul_q30(s_q[2], s_q[0]), SH);
    v_n[6] = rshift(ecvm_pkg::mul_q30(s_q[3], s_q[1]), SH);
    v_n[7] = rshift(s_q[2], SH);
    v_n[8] = rshift(-ecvm_pkg::mul_q30(s_q[3], s_q[0]), SH);
  end
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (en) vb <= va;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      v_q <= v_n;
      pxb <= pxa;
      pyb <= pya;
      pzb <= pza;
    end
  end

  // stage c: products of position with basis (basis magnitude fits 32 bits)
  logic signed [MW-1:0] pr_q [9];
  logic vc;
  a_t [8:0] v_c;
  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else if (en) vc <= vb;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      v_c <= v_q;
      for (int r = 0; r < 3; r++) begin
        pr_q[3*r]   <= pxb * $signed(v_q[3*r][ecvm_pkg::POS_W-1:0]);
        pr_q[3*r+1] <= pyb * $signed(v_q[3*r+1][ecvm_pkg::POS_W-1:0]);
        pr_q[3*r+2] <= pzb * $signed(v_q[3*r+2][ecvm_pkg::POS_W-1:0]);
      end
    end
  end

  // stage d: sum, round, negate, saturate
  always_ff @(posedge clk) begin
    if (rst) vout <= 1'b0;
    else if (en) vout <= vc;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        logic signed [PW-1:0] d, m, t;
        d = PW'(pr_q[3*r]) + PW'(pr_q[3*r+1]) + PW'(pr_q[3*r+2]);
        m = d[PW-1] ? -d : d;
        if (UNIT_FRAC_BITS > 0) m = (m + (PW'(1) <<< (UNIT_FRAC_BITS - 1))) >>> UNIT_FRAC_BITS;
        t = d[PW-1] ? m : -m;
        if (t > $signed(PW'(64'sd4294967295))) t = PW'(64'sd4294967295);
        if (t < $signed(-PW'(64'sd4294967296))) t = -PW'(64'sd4294967296);
        trans[r] <= t[ecvm_pkg::TRANS_W-1:0];
      end
      for (int k = 0; k < 9; k++) unit[k] <= v_c[k][ecvm_pkg::UNIT_W-1:0];
    end
  end
endmodule
`default_nettype wire

FILE: design/euler_camera_view_matrix.sv
// ----------------------------------------------------------------------------
// euler_camera_view_matrix: uvn camera basis and translation from a pose
// Four sine lanes run through a chain of horner cells, then basis and dots.
// ----------------------------------------------------------------------------
// channel | dir | contents
// s_axis  | in  | pose request: angles and position
// m_axis  | out | basis vectors and translation row
// One request accepted per cycle while m_axis is not stalled; each passes the setup register,
// the horner chain and the output stages. Synchronous reset clears the valid bits only.
// The whole chain advances when the output register is empty or taken; a stall
// on m_axis holds every cell.
`default_nettype none
module euler_camera_view_matrix #(
  parameter int ANGLE_BITS     = ecvm_pkg::ANGLE_BITS_DEF,
  parameter int UNIT_FRAC_BITS = ecvm_pkg::UNIT_FRAC_BITS_DEF
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // heading_angle, elevation_angle, pos_x, pos_y, pos_z
  input  wire  [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // right_x,right_y,right_z,up_x,up_y,up_z,look_x,look_y,look_z,
  // trans_right,trans_up,trans_look, zero fill
  output logic [247:0] m_axis_tdata
);
  localparam int FB = ANGLE_BITS - 2;
  typedef logic signed [ecvm_pkg::ACC_W-1:0] a_t;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // lane setup: quadrant fold and u squared
  ecvm_pkg::pose_t c0;
  logic [ANGLE_BITS-1:0] ang [4];
  always_comb begin
    logic [ANGLE_BITS-1:0] h, e, q;
    h = ANGLE_BITS'(s_axis_tdata[15:0]);
    e = ANGLE_BITS'(s_axis_tdata[31:16]);
    q = ANGLE_BITS'(1) << FB;
    ang[0] = h; ang[1] = h + q; ang[2] = e; ang[3] = e + q;
    for (int i = 0; i < 4; i++) begin
      a_t x, u;
      x = a_t'(ang[i][FB-1:0]) <<< (32 - ANGLE_BITS);
      u = ang[i][FB] ? ecvm_pkg::ONE_Q30 - x : x;
      c0.lane[i].u = u;
      c0.lane[i].u2 = ecvm_pkg::mul_q30(u, u);
      c0.lane[i].acc = ecvm_pkg::coef(0);
      c0.lane[i].full = (u == ecvm_pkg::ONE_Q30);
      c0.lane[i].neg = ang[i][ANGLE_BITS-1];
    end
    c0.px = s_axis_tdata[63:32];
    c0.py = s_axis_tdata[95:64];
    c0.pz = s_axis_tdata[127:96];
  end

  ecvm_pkg::pose_t c_q;
  logic v_q;
  always_ff @(posedge clk) begin
    if (rst) v_q <= 1'b0;
    else if (en) v_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) c_q <= c0;
  end

  // horner cell chain
  ecvm_pkg::pose_t cd [ecvm_pkg::NCOEF];
  logic            cv [ecvm_pkg::NCOEF];
  assign cd[0] = c_q;
  assign cv[0] = v_q;
  for (genvar g = 1; g < ecvm_pkg::NCOEF; g++) begin : g_cell
    ecvm_horner_cell #(.STEP(g)) u_cell (
      .clk(clk), .rst(rst), .en(en), .vin(cv[g-1]), .din(cd[g-1]),
      .vout(cv[g]), .dout(cd[g])
    );
  end

  logic [8:0][ecvm_pkg::UNIT_W-1:0]  unit;
  logic [2:0][ecvm_pkg::TRANS_W-1:0] trans;
  ecvm_out_cell #(.UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_out (
    .clk(clk), .rst(rst), .en(en), .vin(cv[ecvm_pkg::NCOEF-1]),
    .din(cd[ecvm_pkg::NCOEF-1]), .vout(m_axis_tvalid), .unit(unit), .trans(trans)
  );

  assign m_axis_tdata = {5'd0, trans[2], trans[1], trans[0], unit};
endmodule
`default_nettype wire
